// ===== rtl/hamming_block_encoder_defines.svh =====
// Assertion macros shared by the Hamming block encoder RTL.
`ifndef HAMMING_BLOCK_ENCODER_DEFINES_SVH
`define HAMMING_BLOCK_ENCODER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define HBE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define HBE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define HBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hbe_pkg.sv =====
// Shared widths and elaboration helpers for the Hamming block encoder.
`default_nettype none

package hbe_pkg;

  localparam int DATA_BITS_W = 6;
  localparam int CODEWORD_W  = 38;
  localparam int CW_BITS_W   = 6;
  localparam int MAX_PARITY  = 7;

  // Smallest r with 2^r >= k + r + 1. Each count covers block lengths up to
  // 2^r - r - 1, so k is compared against those limits in turn.
  function automatic int parity_count(input int k);
    int r;
    priority if (k <= 0) begin
      r = 1;
    end else if (k <= 1) begin
      r = 2;
    end else if (k <= 4) begin
      r = 3;
    end else if (k <= 11) begin
      r = 4;
    end else if (k <= 26) begin
      r = 5;
    end else if (k <= 57) begin
      r = 6;
    end else begin
      r = MAX_PARITY;
    end
    return r;
  endfunction

  // Codeword position of data bit d: the d-th position whose (index + 1)
  // is not a power of two.
  function automatic int data_pos(input int d);
    int pos;
    int seen;
    int q;
    pos  = 0;
    seen = 0;
    for (int p = 0; p < 128; p++) begin
      q = p + 1;
      if ((q & (q - 1)) != 0) begin
        if (seen == d) begin
          pos = p;
        end
        seen = seen + 1;
      end
    end
    return pos;
  endfunction

  // Data bits that feed parity bit i, for a block of nd data bits.
  function automatic logic [63:0] parity_mask(input int i, input int nd);
    logic [63:0] mask;
    mask = '0;
    for (int d = 0; d < nd; d++) begin
      if ((((data_pos(d) + 1) >> i) & 1) != 0) begin
        mask[d] = 1'b1;
      end
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hbe_encoder.sv =====
// Hamming codeword builder: places data bits and forms the parity XOR trees.
`default_nettype none

module hbe_encoder #(
  parameter int MAX_DATA_BITS = 32
) (
  input  wire logic [MAX_DATA_BITS-1:0]         data,
  output logic      [hbe_pkg::CODEWORD_W-1:0]   codeword
);

  localparam int R       = hbe_pkg::parity_count(MAX_DATA_BITS);
  localparam int CW_FULL = MAX_DATA_BITS + R;

  logic [CW_FULL-1:0] cw_full;

  // Data bits go to the positions that are not parity positions, in order.
  for (genvar d = 0; d < MAX_DATA_BITS; d++) begin : g_data
    assign cw_full[hbe_pkg::data_pos(d)] = data[d];
  end

  // Parity bit i sits at 2^i - 1 and covers positions with bit i of (p + 1) set.
  for (genvar i = 0; i < R; i++) begin : g_parity
    localparam logic [63:0] MASK = hbe_pkg::parity_mask(i, MAX_DATA_BITS);
    assign cw_full[(1 << i) - 1] = ^(data & MASK[MAX_DATA_BITS-1:0]);
  end

  // Fit the full codeword to the output field: truncate or zero-fill.
  for (genvar p = 0; p < hbe_pkg::CODEWORD_W; p++) begin : g_out
    if (p < CW_FULL) begin : g_bit
      assign codeword[p] = cw_full[p];
    end else begin : g_zero
      assign codeword[p] = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hamming_block_encoder.sv =====
// Top level of the serial-in Hamming block encoder with a configurable block length.
`default_nettype none

// Message bits arrive one word per unstalled cycle on the input channel, gathered
// into a block of k data bits, k being the data_bits register (0 acts as 1,
// values above MAX_DATA_BITS act as MAX_DATA_BITS; reset value 32). When the
// block is full, or a word arrives with message_end set, the block is zero
// padded to k bits and one Hamming codeword leaves on the output channel:
// parity bits at positions 2^i - 1, data bits in arrival order at the other
// positions, codeword_bits giving the length k + r, and last_block marking a
// block closed by message_end. A new word is taken every cycle that in_stall
// is low. A completed block passes through two registers: the first holds the
// masked block with its length, the second holds the encoded word after the
// parity XOR trees. Those two registers also form a two-deep queue,
// so input words are only held off when both hold a codeword and the output
// is stalled. Words that do not complete a block still need a free first
// register, so the input stall depends on nothing but those two stages.
// If data_bits is lowered while a partial block is held, the block is closed
// by the next word and only its first k bits are encoded. The register is
// to be written only while no word is in flight.

`include "hamming_block_encoder_defines.svh"

module hamming_block_encoder #(
  parameter int MAX_DATA_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_write,
  input  wire logic [hbe_pkg::DATA_BITS_W-1:0]   cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              data_bit,
  input  wire logic                              message_end,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [hbe_pkg::CODEWORD_W-1:0]    codeword,
  output logic      [hbe_pkg::CW_BITS_W-1:0]     codeword_bits,
  output logic                                   last_block
);

  localparam int CNT_W = $clog2(MAX_DATA_BITS + 1);

  // Configuration and collection state.
  logic [hbe_pkg::DATA_BITS_W-1:0] data_bits;
  logic [MAX_DATA_BITS-1:0]        block_buffer;
  logic [CNT_W-1:0]                bits_collected;

  // Block register: a finished, masked block waiting to be encoded.
  logic                            blk_valid;
  logic [MAX_DATA_BITS-1:0]        blk_data;
  logic [hbe_pkg::CW_BITS_W-1:0]   blk_bits;
  logic                            blk_last;

  logic [hbe_pkg::DATA_BITS_W-1:0] k_eff;
  logic [CNT_W-1:0]                cnt_inc;
  logic [MAX_DATA_BITS-1:0]        block_buffer_next;
  logic [MAX_DATA_BITS-1:0]        blk_data_next;
  logic [hbe_pkg::CW_BITS_W-1:0]   blk_bits_next;
  logic                            emit;
  logic                            in_accept;
  logic                            out_adv;
  logic                            blk_adv;
  logic [hbe_pkg::CODEWORD_W-1:0]  enc_codeword;

  // The output register moves when empty or taken; the block register moves
  // when empty or when it can pass its word on.
  assign out_adv   = !out_valid || !out_stall;
  assign blk_adv   = !blk_valid || out_adv;
  assign in_stall  = !blk_adv;
  assign in_accept = in_valid && !in_stall;

  // Effective block length after clamping the register into 1..MAX_DATA_BITS.
  always_comb begin
    priority if (data_bits == '0) begin
      k_eff = hbe_pkg::DATA_BITS_W'(1);
    end else if (int'(data_bits) > MAX_DATA_BITS) begin
      k_eff = hbe_pkg::DATA_BITS_W'(MAX_DATA_BITS);
    end else begin
      k_eff = data_bits;
    end
  end

  // The incoming bit lands at the current fill position; the count stays
  // below MAX_DATA_BITS between words, so the position always exists.
  always_comb begin
    cnt_inc           = bits_collected + CNT_W'(1);
    block_buffer_next = block_buffer;
    for (int j = 0; j < MAX_DATA_BITS; j++) begin
      if (bits_collected == CNT_W'(j)) begin
        block_buffer_next[j] = data_bit;
      end
    end
    emit = (int'(cnt_inc) >= int'(k_eff)) || message_end;
    // Only the first k bits are encoded; anything beyond is dropped.
    for (int j = 0; j < MAX_DATA_BITS; j++) begin
      blk_data_next[j] = block_buffer_next[j] && (j < int'(k_eff));
    end
    blk_bits_next = hbe_pkg::CW_BITS_W'(int'(k_eff) + hbe_pkg::parity_count(int'(k_eff)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits      <= hbe_pkg::DATA_BITS_W'(32);
      block_buffer   <= '0;
      bits_collected <= '0;
    end else begin
      if (cfg_write) begin
        data_bits <= cfg_data;
      end
      if (in_accept) begin
        if (emit) begin
          block_buffer   <= '0;
          bits_collected <= '0;
        end else begin
          block_buffer   <= block_buffer_next;
          bits_collected <= cnt_inc;
        end
      end
    end
  end

  // Block register.
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (blk_adv) begin
      blk_valid <= in_accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_adv && in_accept && emit) begin
      blk_data <= blk_data_next;
      blk_bits <= blk_bits_next;
      blk_last <= message_end;
    end
  end

  hbe_encoder #(
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_encoder (
    .data     (blk_data),
    .codeword (enc_codeword)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && blk_valid) begin
      codeword      <= enc_codeword;
      codeword_bits <= blk_bits;
      last_block    <= blk_last;
    end
  end

  `HBE_ASSERT_ALWAYS(a_fill_bound, clk, rst, int'(bits_collected) < MAX_DATA_BITS, "fill count reached block capacity")
  `HBE_ASSERT_NEXT(a_end_clears, clk, rst, in_accept && message_end, bits_collected == '0, "message end did not clear the block")
  `HBE_ASSERT_NEXT(a_blk_hold, clk, rst, blk_valid && !out_adv, blk_valid && $stable(blk_data) && $stable(blk_bits), "waiting block was overwritten")
  `HBE_ASSERT_IMPL(a_cw_upper_zero, clk, rst, out_valid, (codeword >> codeword_bits) == '0, "codeword has bits beyond its length")

endmodule

`default_nettype wire

// ===== verif/tb_hamming_block_encoder.sv =====
// Self-checking testbench for the serial Hamming block encoder, with random gaps and stalls.
`default_nettype none

// The testbench streams message bits into the encoder one word at a time and
// predicts every codeword in a behavioural model of its own. The model keeps
// its own copy of the block length register, the partly filled block and the
// count of bits held. Expected codewords wait in a queue. A separate receiver
// process pops the oldest one for each codeword that the block hands over, and
// compares it field by field.
//
// Both channels idle at random. Before each word the sender waits a random
// gap up to GAP_MAX, and after each codeword the receiver stalls for the same
// range. Some phases run with no idling at all, so that back-to-back words
// reach the pipeline. One phase also holds the output off for a long stretch
// while words keep coming, which fills the two-stage pipeline and forces the
// input stall.
//
// The block length register is written only while nothing is in flight. A
// partial block may still be held at that point. That is deliberate: it is
// how a length change in the middle of a block gets exercised.

module tb_hamming_block_encoder;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_K       = 32;   // block length limit built into the instance
  localparam int GAP_MAX     = 13;   // longest random gap on either channel
  localparam int HOLD_CYCLES = 300;  // length of the long output hold-off
  localparam int SETTLE      = 8;    // pipeline depth plus margin
  localparam int DRAIN_LIMIT = 5000; // cycles allowed for the final codewords

  // One expected codeword, at the widths of the output ports.
  typedef struct packed {
    logic [hbe_pkg::CODEWORD_W-1:0] cw;
    logic [hbe_pkg::CW_BITS_W-1:0]  n_bits;
    logic                           last;
  } codeword_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [hbe_pkg::DATA_BITS_W-1:0]   cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              data_bit = 1'b0;
  logic                              message_end = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [hbe_pkg::CODEWORD_W-1:0]    codeword;
  logic [hbe_pkg::CW_BITS_W-1:0]     codeword_bits;
  logic                              last_block;

  // Behavioural model state: the register as written, and the block gathered so far.
  logic [hbe_pkg::DATA_BITS_W-1:0]   length_reg;
  logic [63:0]                       held_bits;
  int                                held_count;

  codeword_t                         pending_codewords[$];

  int  error_count    = 0;
  int  words_sent     = 0;
  int  codewords_seen = 0;
  int  lengths_used   = 0;
  bit  tx_burst       = 1'b0;  // the sender sends with no gaps while this is set
  bit  rx_burst       = 1'b0;  // the receiver never stalls while this is set
  bit  hold_request   = 1'b0;  // asks the receiver for one long hold-off

  hamming_block_encoder #(
    .MAX_DATA_BITS(MAX_K)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_bit     (data_bit),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .codeword     (codeword),
    .codeword_bits(codeword_bits),
    .last_block   (last_block)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The block length in force. A register value of zero behaves as one, and
  // anything beyond the built-in limit is clamped to that limit.
  function automatic int active_length();
    int k;
    k = int'(length_reg);
    if (k == 0) begin
      k = 1;
    end
    if (k > MAX_K) begin
      k = MAX_K;
    end
    return k;
  endfunction

  // Number of check bits: the smallest r for which 2^r covers k + r + 1.
  function automatic int check_count_for(input int k);
    int r;
    r = 1;
    while ((1 << r) < k + r + 1) begin
      r++;
    end
    return r;
  endfunction

  // Lays the data bits out in order across the positions that are not check
  // positions. Each set data bit folds its one-based position into a running
  // syndrome. Bit i of that syndrome is then the check bit at position 2^i - 1.
  function automatic logic [hbe_pkg::CODEWORD_W-1:0] hamming_encode(
    input logic [63:0] data, input int k, input int n);
    logic [63:0] word;
    logic [6:0]  syndrome;
    int          d;
    int          q;
    word     = '0;
    syndrome = '0;
    d        = 0;
    for (int p = 0; p < n; p++) begin
      q = p + 1;
      if ((q & (q - 1)) != 0) begin
        if (d < k && data[d]) begin
          word[p]  = 1'b1;
          syndrome = syndrome ^ q[6:0];
        end
        d++;
      end
    end
    for (int i = 0; i < 7; i++) begin
      if (((1 << i) - 1) < n && syndrome[i]) begin
        word[(1 << i) - 1] = 1'b1;
      end
    end
    return word[hbe_pkg::CODEWORD_W-1:0];
  endfunction

  // Moves the model on by one accepted word. A codeword is queued once the
  // block is full or the message ends. If the block length was lowered while
  // a longer block was held, only the first k bits take part and the rest are
  // dropped.
  function automatic void absorb_word(input logic bit_value, input logic end_flag);
    int          k;
    int          n;
    logic [63:0] data;
    codeword_t   exp;
    k = active_length();
    if (held_count < 64 && bit_value) begin
      held_bits[held_count] = 1'b1;
    end
    if (held_count < 63) begin
      held_count++;
    end
    if (held_count < k && !end_flag) begin
      return;
    end
    n    = k + check_count_for(k);
    data = held_bits & ((64'd1 << k) - 64'd1);
    exp.cw     = hamming_encode(data, k, n);
    exp.n_bits = n[hbe_pkg::CW_BITS_W-1:0];
    exp.last   = end_flag;
    pending_codewords.insert(pending_codewords.size(), exp);
    held_bits  = '0;
    held_count = 0;
  endfunction

  // Offers one word after a random gap and holds it steady until it is
  // accepted. The valid stays high across back-to-back words, so they follow
  // one another with no gap.
  task automatic send_word(input logic bit_value, input logic end_flag);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_bit    <= bit_value;
    message_end <= end_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_word(bit_value, end_flag);
    words_sent++;
  endtask

  // Lowers the input valid and waits until every expected codeword has come
  // out. It then lets the pipeline settle, since the last word may not have
  // produced a codeword at all.
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_codewords.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the block length register for one cycle and updates the model's copy.
  task automatic write_length(input int value);
    cfg_write <= 1'b1;
    cfg_data  <= value[hbe_pkg::DATA_BITS_W-1:0];
    @(posedge clk);
    cfg_write  <= 1'b0;
    length_reg  = value[hbe_pkg::DATA_BITS_W-1:0];
    lengths_used++;
  endtask

  // Most of the stimulus is whole messages of random length that end with the
  // end flag. Their content is random, all zeros or all ones. About one pick
  // in five is one noise word with a random end flag. A message that the budget
  // cuts short is left open, and the next phase inherits its partial block.
  task automatic run_messages(input int budget);
    int   sent;
    int   len;
    int   pattern;
    int   k;
    logic b;
    sent = 0;
    k    = active_length();
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        len     = $urandom_range(1, 2 * k + 2);
        pattern = $urandom_range(0, 3);
        for (int i = 0; i < len && sent < budget; i++) begin
          b = (pattern == 0) ? 1'b0 : (pattern == 1) ? 1'b1 : 1'($urandom_range(0, 1));
          send_word(b, i == len - 1);
          sent++;
        end
      end else begin
        send_word(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        sent++;
      end
    end
  endtask

  // The reset value of the register must give full 32-bit blocks without any write.
  task automatic test_reset_length();
    run_messages(100);
    drain_words();
  endtask

  // Short directed part: the shortest block, a zero register, all-ones data, a
  // padded tail block, a final bit that exactly fills the block, and a block
  // length lowered while a longer block is held.
  task automatic test_directed();
    write_length(1);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b1);
    drain_words();

    write_length(0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    drain_words();

    write_length(4);
    repeat (4) send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b1);
    drain_words();

    // Five bits are held when the length drops to two. The next word closes
    // the block, and only the first two bits are encoded.
    write_length(8);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b0);
    drain_words();
    write_length(2);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    drain_words();
  endtask

  // Walks through many block lengths: every edge at which the check-bit count
  // changes, the limit, values past the limit, zero, and a few drawn at random.
  // Roughly one phase in four runs with no idling on either side.
  task automatic test_random_lengths();
    int settings[16] = '{1, 2, 3, 4, 5, 10, 11, 12, 25, 26, 27, 31, 32, 33, 63, 0};
    for (int i = 0; i < 20; i++) begin
      write_length(i < 16 ? settings[i] : $urandom_range(0, 63));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = tx_burst;
      run_messages(70);
      drain_words();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // With one-bit blocks every word yields a codeword. A long output hold-off
  // therefore fills both pipeline stages and must push back on the input.
  task automatic test_backpressure();
    write_length(1);
    tx_burst     = 1'b1;
    hold_request = 1'b1;
    repeat (60) send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    tx_burst = 1'b0;
    drain_words();
  endtask

  // Compares one delivered codeword against the oldest expectation.
  task automatic check_codeword();
    codeword_t exp;
    codewords_seen++;
    if (pending_codewords.size() == 0) begin
      $error("codeword %h (%0d bits) arrived with no expectation", codeword, codeword_bits);
      error_count++;
      return;
    end
    exp = pending_codewords.pop_front();
    if (codeword !== exp.cw) begin
      $error("codeword: expected %h, actual %h", exp.cw, codeword);
      error_count++;
    end
    if (codeword_bits !== exp.n_bits) begin
      $error("codeword_bits: expected %0d, actual %0d", exp.n_bits, codeword_bits);
      error_count++;
    end
    if (last_block !== exp.last) begin
      $error("last_block: expected %0b, actual %0b", exp.last, last_block);
      error_count++;
    end
  endtask

  // Receiver: samples the handshake at each rising edge and picks a fresh
  // stall after every codeword. It also serves the long hold-off, counting
  // that stretch here.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && !out_stall) begin
        check_codeword();
        stall_left = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Stops a run that hangs. The limit is several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int waited;
    length_reg = 6'd32;
    held_bits  = '0;
    held_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_length();
    test_directed();
    test_random_lengths();
    test_backpressure();

    // Final drain, with a limit. Expectations still waiting after it count as failures.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_codewords.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_codewords.size() != 0) begin
      $error("%0d expected codewords never arrived", pending_codewords.size());
      error_count++;
    end
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d words and %0d codewords across %0d block length writes.",
             words_sent, codewords_seen, lengths_used);
    $display("Lengths from zero to 63 were used, with random idling and a long output hold-off.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
